@@ rtl/core/xbs_pkg.sv @@
package xbs_pkg;

  localparam logic [7:0] SYM_SOH = 8'h01;
  localparam logic [7:0] SYM_EOT = 8'h04;
  localparam logic [7:0] SYM_ACK = 8'h06;
  localparam logic [7:0] SYM_NAK = 8'h15;
  localparam logic [7:0] SYM_CAN = 8'h18;
  localparam logic [7:0] SYM_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] ADDR_CHECKSUM_MODE = 2'd0;

  localparam logic [2:0] PHC_WAIT_START = 3'd0;
  localparam logic [2:0] PHC_LOAD       = 3'd1;
  localparam logic [2:0] PHC_SEND       = 3'd2;
  localparam logic [2:0] PHC_WAIT_ACK   = 3'd3;
  localparam logic [2:0] PHC_SEND_EOT   = 3'd4;
  localparam logic [2:0] PHC_DONE       = 3'd5;
  localparam logic [2:0] PHC_ERROR      = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CANCEL   = 2'd1;
  localparam logic [1:0] ERR_RESPONSE = 2'd2;
  localparam logic [1:0] ERR_REJECT   = 2'd3;

  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_EOD     = 2'd1,
    OP_RX      = 2'd2,
    OP_PULL    = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    PH_WAIT_START = 7'b0000001,
    PH_LOAD       = 7'b0000010,
    PH_SEND       = 7'b0000100,
    PH_WAIT_ACK   = 7'b0001000,
    PH_SEND_EOT   = 7'b0010000,
    PH_DONE       = 7'b0100000,
    PH_ERROR      = 7'b1000000
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       rx_ack;
    logic       rx_nak;
    logic       rx_can;
    logic       rx_c;
  } cmd_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] phase;
    logic [1:0] error_code;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_WAIT_START: code = PHC_WAIT_START;
      PH_LOAD:       code = PHC_LOAD;
      PH_SEND:       code = PHC_SEND;
      PH_WAIT_ACK:   code = PHC_WAIT_ACK;
      PH_SEND_EOT:   code = PHC_SEND_EOT;
      PH_DONE:       code = PHC_DONE;
      default:       code = PHC_ERROR;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/xbs_ram.sv @@
module xbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/xbs_fifo.sv @@
module xbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/core/xbs_front.sv @@
module xbs_front
  import xbs_pkg::*;
(
  input  logic [1:0] op,
  input  logic [7:0] payload_byte,
  input  logic [7:0] rx_byte,
  output cmd_t       cmd
);

  always_comb begin
    cmd.op     = op_t'(op);
    cmd.data   = payload_byte;
    cmd.rx_ack = (rx_byte == SYM_ACK);
    cmd.rx_nak = (rx_byte == SYM_NAK);
    cmd.rx_can = (rx_byte == SYM_CAN);
    cmd.rx_c   = (rx_byte == SYM_C);
  end

endmodule

@@ rtl/core/xbs_back.sv @@
module xbs_back
  import xbs_pkg::*;
#(
  parameter int BLOCK_BYTES = 128
) (
  input  logic clk,
  input  logic rst_n,
  input  logic checksum_mode,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int POS_W  = $clog2(BLOCK_BYTES + 5);
  localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
  localparam int AW     = $clog2(BLOCK_BYTES);

  localparam logic [POS_W-1:0] POS_DATA0 = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CHK   = POS_W'(3 + BLOCK_BYTES);
  localparam logic [POS_W-1:0] POS_CRCLO = POS_W'(4 + BLOCK_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_count_r, fill_count_nxt;
  logic [POS_W-1:0]  send_pos_r, send_pos_nxt;
  logic [7:0]        block_num_r, block_num_nxt;
  logic              final_block_r, final_block_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        sum_r, sum_nxt;

  logic              go;
  logic              buf_we;
  logic [7:0]        buf_rdata;
  logic [POS_W-1:0]  data_idx;
  logic [POS_W-1:0]  rd_idx;
  logic [POS_W-1:0]  last_pos;
  logic [7:0]        frame_byte;

  assign go       = cmd_valid && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;
  assign data_idx = send_pos_r - POS_DATA0;
  assign rd_idx   = send_pos_nxt - POS_DATA0;
  assign last_pos = checksum_mode ? POS_CRCLO : POS_CHK;

  xbs_ram #(
    .WIDTH(8),
    .DEPTH(BLOCK_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(fill_count_r[AW-1:0]),
    .wdata(cmd.data),
    .raddr(rd_idx[AW-1:0]),
    .rdata(buf_rdata)
  );

  always_comb begin
    phase_nxt       = phase_r;
    fill_count_nxt  = fill_count_r;
    send_pos_nxt    = send_pos_r;
    block_num_nxt   = block_num_r;
    final_block_nxt = final_block_r;
    crc_nxt         = crc_r;
    sum_nxt         = sum_r;
    buf_we          = 1'b0;
    frame_byte      = 8'h00;
    res.tx_valid    = 1'b0;
    res.tx_byte     = 8'h00;
    res.error_code  = ERR_NONE;

    if (send_pos_r == '0) begin
      frame_byte = SYM_SOH;
    end else if (send_pos_r == POS_W'(1)) begin
      frame_byte = block_num_r;
    end else if (send_pos_r == POS_W'(2)) begin
      frame_byte = ~block_num_r;
    end else if (send_pos_r < POS_CHK) begin
      frame_byte = (data_idx < POS_W'(fill_count_r)) ? buf_rdata : 8'h00;
    end else if (send_pos_r == POS_CHK) begin
      frame_byte = checksum_mode ? crc_r[15:8] : sum_r;
    end else begin
      frame_byte = crc_r[7:0];
    end

    if (go) begin
      case (phase_r)
        PH_WAIT_START: begin
          if (cmd.op == OP_RX) begin
            if ((!checksum_mode && cmd.rx_nak) || (checksum_mode && cmd.rx_c)) begin
              phase_nxt = PH_LOAD;
            end
          end else begin
            res.error_code = ERR_REJECT;
          end
        end
        PH_LOAD: begin
          if (cmd.op == OP_PAYLOAD) begin
            buf_we         = 1'b1;
            fill_count_nxt = fill_count_r + 1'b1;
            if (fill_count_nxt >= FILL_W'(BLOCK_BYTES)) begin
              send_pos_nxt = '0;
              phase_nxt    = PH_SEND;
            end
          end else if (cmd.op == OP_EOD) begin
            final_block_nxt = 1'b1;
            if (fill_count_r == '0) begin
              phase_nxt = PH_SEND_EOT;
            end else begin
              send_pos_nxt = '0;
              phase_nxt    = PH_SEND;
            end
          end else begin
            res.error_code = ERR_REJECT;
          end
        end
        PH_SEND: begin
          if (cmd.op == OP_PULL) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = frame_byte;
            if (send_pos_r == '0) begin
              crc_nxt = '0;
              sum_nxt = '0;
            end else if (send_pos_r >= POS_DATA0 && send_pos_r < POS_CHK) begin
              crc_nxt = crc_byte(crc_r, frame_byte);
              sum_nxt = sum_r + frame_byte;
            end
            if (send_pos_r >= last_pos) begin
              send_pos_nxt = '0;
              phase_nxt    = PH_WAIT_ACK;
            end else begin
              send_pos_nxt = send_pos_r + 1'b1;
            end
          end else begin
            res.error_code = ERR_REJECT;
          end
        end
        PH_WAIT_ACK: begin
          if (cmd.op == OP_RX) begin
            if (cmd.rx_ack) begin
              block_num_nxt  = block_num_r + 1'b1;
              fill_count_nxt = '0;
              send_pos_nxt   = '0;
              phase_nxt      = final_block_r ? PH_SEND_EOT : PH_LOAD;
            end else if (cmd.rx_nak) begin
              send_pos_nxt = '0;
              phase_nxt    = PH_SEND;
            end else if (cmd.rx_can) begin
              phase_nxt      = PH_ERROR;
              res.error_code = ERR_CANCEL;
            end else begin
              phase_nxt      = PH_ERROR;
              res.error_code = ERR_RESPONSE;
            end
          end else begin
            res.error_code = ERR_REJECT;
          end
        end
        PH_SEND_EOT: begin
          if (cmd.op == OP_PULL) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = SYM_EOT;
            phase_nxt    = PH_DONE;
          end else begin
            res.error_code = ERR_REJECT;
          end
        end
        PH_DONE: begin
          res.error_code = ERR_REJECT;
        end
        default: begin
          phase_nxt      = PH_ERROR;
          res.error_code = ERR_REJECT;
        end
      endcase
    end

    res.phase = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WAIT_START;
      fill_count_r  <= '0;
      send_pos_r    <= '0;
      block_num_r   <= 8'd1;
      final_block_r <= 1'b0;
      crc_r         <= '0;
      sum_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      fill_count_r  <= fill_count_nxt;
      send_pos_r    <= send_pos_nxt;
      block_num_r   <= block_num_nxt;
      final_block_r <= final_block_nxt;
      crc_r         <= crc_nxt;
      sum_r         <= sum_nxt;
    end
  end

  a_pos_only_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    (send_pos_r != '0) |-> (phase_r == PH_SEND))
    else $error("Frame position is nonzero outside the send phase.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= FILL_W'(BLOCK_BYTES))
    else $error("Fill count exceeds the block size.");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    send_pos_r <= POS_CRCLO)
    else $error("Frame position runs past the end of the frame.");

  a_tx_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res.tx_valid) |-> (phase_r == PH_SEND || phase_r == PH_SEND_EOT))
    else $error("A byte was transmitted outside a send phase.");

  a_wait_ack_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (go && phase_r == PH_SEND && cmd.op == OP_PULL && send_pos_r >= last_pos)
    |=> (phase_r == PH_WAIT_ACK && send_pos_r == '0))
    else $error("Frame end did not move to the acknowledge wait.");

endmodule

@@ rtl/core/xmodem_block_sender.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+------------------------------
// input    | in_op, in_payload_byte, in_rx_byte                 | push, full
// result   | out_tx_valid, out_tx_byte, out_phase, out_error_code | empty, pop
// config   | paddr, pwdata, prdata                              | psel, penable, pwrite, pready
//
// One item is accepted per cycle while full is low and yields exactly one result item.
// An accepted item waits in the command queue until the frame sequencer takes it, and its result
// is registered in the result queue, from which it can be popped; the frame sequencer reads
// the block buffer RAM one byte ahead of each pull.
// Reset is synchronous and active low; the block buffer is not cleared.
// full rises when the two-entry command queue is full; the sequencer stalls
// while the two-entry result queue is full.
module xmodem_block_sender
  import xbs_pkg::*;
#(
  parameter int BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_payload_byte,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic [2:0]  out_phase,
  output logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic checksum_mode_r, checksum_mode_nxt;
  cmd_t in_cmd, q_cmd;
  logic q_empty, q_pop;
  logic res_full, res_push;
  res_t back_res, out_res;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CHECKSUM_MODE) ? {31'd0, checksum_mode_r} : 32'd0;

  always_comb begin
    checksum_mode_nxt = checksum_mode_r;
    if (psel && penable && pwrite && pready && paddr == ADDR_CHECKSUM_MODE) begin
      checksum_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_mode_r <= 1'b0;
    end else begin
      checksum_mode_r <= checksum_mode_nxt;
    end
  end

  xbs_front u_front (
    .op          (in_op),
    .payload_byte(in_payload_byte),
    .rx_byte     (in_rx_byte),
    .cmd         (in_cmd)
  );

  xbs_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(in_cmd),
    .full   (full),
    .pop    (q_pop),
    .rd_data(q_cmd),
    .empty  (q_empty)
  );

  xbs_back #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .checksum_mode(checksum_mode_r),
    .cmd_valid    (!q_empty),
    .cmd          (q_cmd),
    .cmd_pop      (q_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (back_res)
  );

  xbs_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(back_res),
    .full   (res_full),
    .pop    (pop),
    .rd_data(out_res),
    .empty  (empty)
  );

  assign out_tx_valid   = out_res.tx_valid;
  assign out_tx_byte    = out_res.tx_byte;
  assign out_phase      = out_res.phase;
  assign out_error_code = out_res.error_code;

endmodule

@@ test/tb_xmodem_block_sender.sv @@
module tb_xmodem_block_sender
  import xbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_BYTES = 128;
  localparam int FRAME_CK_POS = 3 + BLOCK_BYTES;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  class xmodem_scoreboard;
    logic        mode;
    logic [2:0]  phase;
    logic [7:0]  data_buf [BLOCK_BYTES];
    int          fill;
    int          pos;
    logic [7:0]  blk;
    logic        last_block;
    logic [15:0] crc;
    logic [7:0]  sum;
    res_t        expected_tx [$];
    int          errors;
    int          checked;

    function new();
      mode = 1'b0;
      phase = PHC_WAIT_START;
      fill = 0;
      pos = 0;
      blk = 8'd1;
      last_block = 1'b0;
      crc = '0;
      sum = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return expected_tx.size();
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(op_t op, logic [7:0] pay, logic [7:0] rx);
      res_t        r;
      logic        rej;
      int          last_pos;
      int          k;
      logic [7:0]  b;
      logic [15:0] c;
      r = '0;
      rej = 1'b0;
      case (phase)
        PHC_WAIT_START: begin
          if (op == OP_RX) begin
            if ((!mode && rx == SYM_NAK) || (mode && rx == SYM_C)) phase = PHC_LOAD;
          end else begin
            rej = 1'b1;
          end
        end
        PHC_LOAD: begin
          if (op == OP_PAYLOAD) begin
            data_buf[fill] = pay;
            fill++;
            if (fill >= BLOCK_BYTES) begin
              pos = 0;
              phase = PHC_SEND;
            end
          end else if (op == OP_EOD) begin
            last_block = 1'b1;
            if (fill == 0) begin
              phase = PHC_SEND_EOT;
            end else begin
              pos = 0;
              phase = PHC_SEND;
            end
          end else begin
            rej = 1'b1;
          end
        end
        PHC_SEND: begin
          if (op == OP_PULL) begin
            last_pos = mode ? FRAME_CK_POS + 1 : FRAME_CK_POS;
            if (pos == 0) begin
              crc = '0;
              sum = '0;
              b = SYM_SOH;
            end else if (pos == 1) begin
              b = blk;
            end else if (pos == 2) begin
              b = 8'd255 - blk;
            end else if (pos < FRAME_CK_POS) begin
              b = (pos - 3 < fill) ? data_buf[pos - 3] : 8'h00;
              c = crc ^ {b, 8'h00};
              for (k = 0; k < 8; k++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
              end
              crc = c;
              sum = sum + b;
            end else if (pos == FRAME_CK_POS) begin
              b = mode ? crc[15:8] : sum;
            end else begin
              b = crc[7:0];
            end
            if (pos >= last_pos) begin
              pos = 0;
              phase = PHC_WAIT_ACK;
            end else begin
              pos++;
            end
            r.tx_valid = 1'b1;
            r.tx_byte = b;
          end else begin
            rej = 1'b1;
          end
        end
        PHC_WAIT_ACK: begin
          if (op == OP_RX) begin
            if (rx == SYM_ACK) begin
              blk = blk + 8'd1;
              fill = 0;
              pos = 0;
              phase = last_block ? PHC_SEND_EOT : PHC_LOAD;
            end else if (rx == SYM_NAK) begin
              pos = 0;
              phase = PHC_SEND;
            end else if (rx == SYM_CAN) begin
              phase = PHC_ERROR;
              r.error_code = ERR_CANCEL;
            end else begin
              phase = PHC_ERROR;
              r.error_code = ERR_RESPONSE;
            end
          end else begin
            rej = 1'b1;
          end
        end
        PHC_SEND_EOT: begin
          if (op == OP_PULL) begin
            r.tx_valid = 1'b1;
            r.tx_byte = SYM_EOT;
            phase = PHC_DONE;
          end else begin
            rej = 1'b1;
          end
        end
        default: begin
          if (phase != PHC_DONE) phase = PHC_ERROR;
          rej = 1'b1;
        end
      endcase
      if (rej) r.error_code = ERR_REJECT;
      r.phase = phase;
      expected_tx.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_tx.size() == 0) begin
        $error("result with no item waiting: tx_byte 0x%0h", got.tx_byte);
        errors++;
      end else begin
        want = expected_tx.pop_front();
        compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        compare_field("tx_byte", want.tx_byte, got.tx_byte);
        compare_field("phase", 8'(want.phase), 8'(got.phase));
        compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
      end
      checked++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_op = 2'd0;
  logic [7:0]  in_payload_byte = 8'h00;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic [2:0]  out_phase;
  logic [1:0]  out_error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  xmodem_scoreboard sb;
  int tx_streak = 0;
  int rx_streak = 0;
  int n_items = 0;
  int n_writes = 0;
  int idle_cycles = 0;
  logic gen_mode = 1'b0;

  xmodem_block_sender dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_payload_byte(in_payload_byte),
    .in_rx_byte     (in_rx_byte),
    .empty          (empty),
    .pop            (pop),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_phase      (out_phase),
    .out_error_code (out_error_code),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int gap_draw(inout int streak);
    int r;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) streak = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_item(op_t op, logic [7:0] d);
    int g;
    logic [7:0] pay;
    logic [7:0] rx;
    g = gap_draw(tx_streak);
    pay = (op == OP_PAYLOAD) ? d : 8'($urandom);
    rx = (op == OP_RX) ? d : 8'($urandom);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_payload_byte <= pay;
    in_rx_byte <= rx;
    do @(posedge clk); while (full);
    sb.note_item(op, pay, rx);
    n_items++;
  endtask

  // Occasionally slips in an item that the current phase rejects.
  task automatic maybe_noise(logic [2:0] ph);
    op_t o;
    if ($urandom_range(0, 15) != 0) return;
    do o = op_t'($urandom_range(0, 3));
    while ((ph == PHC_LOAD && (o == OP_PAYLOAD || o == OP_EOD)) ||
           ((ph == PHC_SEND || ph == PHC_SEND_EOT) && o == OP_PULL) ||
           (ph == PHC_WAIT_ACK && o == OP_RX));
    push_item(o, 8'($urandom));
  endtask

  task automatic write_mode(logic m);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_CHECKSUM_MODE;
    pwdata <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(m)) begin
      $error("checksum_mode: expected 0x%0h, got 0x%0h", m, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_mode(m);
    gen_mode = m;
    n_writes++;
  endtask

  // Pulls one frame; the mode may be switched just before a chosen position.
  task automatic send_frame(int switch_at);
    int p;
    bit frame_end;
    p = 0;
    do begin
      if (p == switch_at) write_mode(!gen_mode);
      maybe_noise(PHC_SEND);
      push_item(OP_PULL, 8'h00);
      frame_end = (p >= (gen_mode ? FRAME_CK_POS + 1 : FRAME_CK_POS));
      p++;
    end while (!frame_end);
  endtask

  task automatic run_block(int n, int preloaded, bit is_last, int switch_at, int naks,
                           logic [7:0] reply);
    int i;
    for (i = preloaded; i < n; i++) begin
      maybe_noise(PHC_LOAD);
      push_item(OP_PAYLOAD, 8'($urandom));
    end
    if (is_last) begin
      maybe_noise(PHC_LOAD);
      push_item(OP_EOD, 8'h00);
    end
    if (n > 0) begin
      send_frame(switch_at);
      repeat (naks) begin
        maybe_noise(PHC_WAIT_ACK);
        push_item(OP_RX, SYM_NAK);
        send_frame(-1);
      end
      maybe_noise(PHC_WAIT_ACK);
      push_item(OP_RX, reply);
    end
  endtask

  initial begin : result_side
    res_t got;
    int wait_left;
    bit held;
    wait_left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got = '{out_tx_valid, out_tx_byte, out_phase, out_error_code};
        sb.check_result(got);
        wait_left = gap_draw(rx_streak);
      end
      if (!held && sb.checked >= HOLD_AFTER && push) begin
        held = 1'b1;
        wait_left = HOLD_CYCLES;
      end
      if (wait_left > 0) begin
        pop <= 1'b0;
        wait_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sw;
    int ending;
    int len;
    logic [7:0] bad;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b1);
    push_item(OP_PAYLOAD, 8'hFF);
    push_item(OP_EOD, 8'h00);
    push_item(OP_PULL, 8'h00);
    push_item(OP_RX, SYM_NAK);
    push_item(OP_RX, 8'h00);
    push_item(OP_RX, 8'hFF);
    push_item(OP_RX, SYM_C);
    push_item(OP_RX, SYM_ACK);
    push_item(OP_PULL, 8'h00);
    push_item(OP_PAYLOAD, 8'h00);
    push_item(OP_PAYLOAD, 8'hFF);
    push_item(OP_PAYLOAD, 8'h80);
    push_item(OP_PAYLOAD, 8'h01);
    // Switch to the sum mode after the first CRC byte so the next pull is the CRC low byte.
    run_block(BLOCK_BYTES, 4, 1'b0, FRAME_CK_POS + 1, 1, SYM_ACK);

    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0) begin
        sw = -1;
      end else if ($urandom_range(0, 1) == 1) begin
        sw = FRAME_CK_POS + $urandom_range(0, 1);
      end else begin
        sw = $urandom_range(1, FRAME_CK_POS - 1);
      end
      run_block(BLOCK_BYTES, 0, 1'b0, sw, ($urandom_range(0, 3) == 0) ? 1 : 0, SYM_ACK);
    end

    ending = $urandom_range(0, 3);
    len = $urandom_range(1, BLOCK_BYTES - 1);
    do bad = 8'($urandom); while (bad == SYM_ACK || bad == SYM_NAK || bad == SYM_CAN);
    case (ending)
      0: run_block(0, 0, 1'b1, -1, 0, SYM_ACK);
      1: run_block(len, 0, 1'b1, -1, $urandom_range(0, 1), SYM_ACK);
      2: run_block(len, 0, 1'b1, -1, 0, SYM_CAN);
      default: run_block(len, 0, 1'b1, -1, 0, bad);
    endcase
    if (ending < 2) begin
      maybe_noise(PHC_SEND_EOT);
      push_item(OP_PULL, 8'h00);
    end
    repeat (8) push_item(op_t'($urandom_range(0, 3)), 8'($urandom));

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d items over one transfer with %0d mode writes; %0d results checked.",
             n_items, n_writes, sb.checked);
    $display("The transfer ended in phase %0d after %0d blocks.", sb.phase, sb.blk - 8'd1);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/xbs_pkg.sv
rtl/core/xbs_ram.sv
rtl/core/xbs_fifo.sv
rtl/core/xbs_front.sv
rtl/core/xbs_back.sv
rtl/core/xmodem_block_sender.sv
test/tb_xmodem_block_sender.sv
